FILE: hdl/pdat_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pdat_pkg
// Shared widths, register indexes and controller command types for the
// pose deviation adaptive threshold block.
// ----------------------------------------------------------------------------
package pdat_pkg;

    localparam int COUNT_WIDTH_DEF = 24;
    localparam int FRAC_BITS_DEF   = 16;

    localparam int ROT_W     = 16;
    localparam int ROT_FRAC  = 14;
    localparam int TRANS_W   = 32;
    localparam int DISP_W    = 32;
    localparam int CFG_W     = 24;
    localparam int CFG_IDX_W = 1;
    localparam int RAD_W     = 128;
    localparam int ROOT_RES_W = 64;
    localparam int ACC_W     = 129;
    localparam int ITER      = 64;

    localparam logic [CFG_IDX_W-1:0] REG_MAX_RANGE     = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_DEVIATION = 1'b1;

    localparam logic [CFG_W-1:0] MAX_RANGE_RST = 24'd6553600;
    localparam logic [CFG_W-1:0] MIN_DEV_RST   = 24'd6554;

    typedef enum logic [3:0] {
        MUL_NONE,
        MUL_ROT,
        MUL_TX,
        MUL_TY,
        MUL_TZ,
        MUL_DISP,
        MUL_NSQ_LO,
        MUL_NSQ_HI,
        MUL_SLL,
        MUL_SLH,
        MUL_SHL,
        MUL_SHH
    } mul_sel_t;

    typedef enum logic [1:0] {
        ACC_HOLD,
        ACC_LOAD,
        ACC_ADD,
        ACC_SUB
    } acc_op_t;

    typedef enum logic [1:0] {
        SH_0,
        SH_32,
        SH_64
    } acc_sh_t;

    typedef enum logic [1:0] {
        SQ_NONE,
        SQ_ROOT,
        SQ_TRANS,
        SQ_DEV
    } sq_load_t;

    typedef struct packed {
        logic     load_in;
        sq_load_t sq_load;
        logic     sq_step;
        logic     div_load;
        logic     div_step;
        logic     rot_cap;
        logic     disp_cap;
        logic     stat_upd;
        logic     thr_cap;
        logic     out_load;
        mul_sel_t mul_sel;
        acc_op_t  acc_op;
        acc_sh_t  acc_sh;
    } pdat_cmd_t;

    typedef struct packed {
        logic iter_last;
        logic take;
        logic out_free;
    } pdat_status_t;

endpackage

FILE: hdl/pdat_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pdat_if
// Valid/ready channels for pose words in and threshold result words out.
// ----------------------------------------------------------------------------
interface pdat_pose_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] rot_diag_0;
    logic signed [15:0] rot_diag_1;
    logic signed [15:0] rot_diag_2;
    logic signed [31:0] trans_x;
    logic signed [31:0] trans_y;
    logic signed [31:0] trans_z;

    modport source (output valid, rot_diag_0, rot_diag_1, rot_diag_2,
                    trans_x, trans_y, trans_z, input ready);
    modport sink   (input valid, rot_diag_0, rot_diag_1, rot_diag_2,
                    trans_x, trans_y, trans_z, output ready);
endinterface

interface pdat_result_if;
    logic        valid;
    logic        ready;
    logic [31:0] displacement;
    logic        accepted;
    logic [31:0] threshold;
    logic        saturated;

    modport source (output valid, displacement, accepted, threshold, saturated,
                    input ready);
    modport sink   (input valid, displacement, accepted, threshold, saturated,
                    output ready);
endinterface

FILE: hdl/pdat_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pdat_ctrl
// Sequencer: walks one pose word through root, translation norm, statistics
// update and, if the sample is taken, deviation root and division.
// ----------------------------------------------------------------------------
module pdat_ctrl
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   pose_valid,
    output logic                   pose_ready,
    input  pdat_pkg::pdat_status_t status,
    output pdat_pkg::pdat_cmd_t    cmd
);
    import pdat_pkg::*;

    typedef enum logic [25:0] {
        S_IDLE       = 26'd1 << 0,
        S_ROOT_INIT  = 26'd1 << 1,
        S_ROOT       = 26'd1 << 2,
        S_ROT        = 26'd1 << 3,
        S_TX         = 26'd1 << 4,
        S_TY         = 26'd1 << 5,
        S_TZ         = 26'd1 << 6,
        S_TSUM       = 26'd1 << 7,
        S_TROOT_INIT = 26'd1 << 8,
        S_TROOT      = 26'd1 << 9,
        S_DISP       = 26'd1 << 10,
        S_SQUARE     = 26'd1 << 11,
        S_DECIDE     = 26'd1 << 12,
        S_NS0        = 26'd1 << 13,
        S_NS1        = 26'd1 << 14,
        S_SS0        = 26'd1 << 15,
        S_SS1        = 26'd1 << 16,
        S_SS2        = 26'd1 << 17,
        S_SS3        = 26'd1 << 18,
        S_SS4        = 26'd1 << 19,
        S_DROOT_INIT = 26'd1 << 20,
        S_DROOT      = 26'd1 << 21,
        S_DIV_INIT   = 26'd1 << 22,
        S_DIV        = 26'd1 << 23,
        S_THR        = 26'd1 << 24,
        S_OUT        = 26'd1 << 25
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign pose_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.sq_load = SQ_NONE;
        cmd.mul_sel = MUL_NONE;
        cmd.acc_op  = ACC_HOLD;
        cmd.acc_sh  = SH_0;
        case (state_reg)
            S_IDLE:
            begin
                if (pose_valid)
                begin
                    cmd.load_in = 1'b1;
                    state_next  = S_ROOT_INIT;
                end
            end
            S_ROOT_INIT:
            begin
                cmd.sq_load = SQ_ROOT;
                state_next  = S_ROOT;
            end
            S_ROOT:
            begin
                cmd.sq_step = 1'b1;
                if (status.iter_last)
                begin
                    state_next = S_ROT;
                end
            end
            S_ROT:
            begin
                cmd.mul_sel = MUL_ROT;
                state_next  = S_TX;
            end
            S_TX:
            begin
                cmd.rot_cap = 1'b1;
                cmd.mul_sel = MUL_TX;
                state_next  = S_TY;
            end
            S_TY:
            begin
                cmd.acc_op  = ACC_LOAD;
                cmd.mul_sel = MUL_TY;
                state_next  = S_TZ;
            end
            S_TZ:
            begin
                cmd.acc_op  = ACC_ADD;
                cmd.mul_sel = MUL_TZ;
                state_next  = S_TSUM;
            end
            S_TSUM:
            begin
                cmd.acc_op = ACC_ADD;
                state_next = S_TROOT_INIT;
            end
            S_TROOT_INIT:
            begin
                cmd.sq_load = SQ_TRANS;
                state_next  = S_TROOT;
            end
            S_TROOT:
            begin
                cmd.sq_step = 1'b1;
                if (status.iter_last)
                begin
                    state_next = S_DISP;
                end
            end
            S_DISP:
            begin
                cmd.disp_cap = 1'b1;
                state_next   = S_SQUARE;
            end
            S_SQUARE:
            begin
                cmd.mul_sel = MUL_DISP;
                state_next  = S_DECIDE;
            end
            S_DECIDE:
            begin
                cmd.stat_upd = 1'b1;
                if (status.take)
                begin
                    state_next = S_NS0;
                end
                else
                begin
                    state_next = S_OUT;
                end
            end
            S_NS0:
            begin
                cmd.mul_sel = MUL_NSQ_LO;
                state_next  = S_NS1;
            end
            S_NS1:
            begin
                cmd.acc_op  = ACC_LOAD;
                cmd.mul_sel = MUL_NSQ_HI;
                state_next  = S_SS0;
            end
            S_SS0:
            begin
                cmd.acc_op  = ACC_ADD;
                cmd.acc_sh  = SH_32;
                cmd.mul_sel = MUL_SLL;
                state_next  = S_SS1;
            end
            S_SS1:
            begin
                cmd.acc_op  = ACC_SUB;
                cmd.mul_sel = MUL_SLH;
                state_next  = S_SS2;
            end
            S_SS2:
            begin
                cmd.acc_op  = ACC_SUB;
                cmd.acc_sh  = SH_32;
                cmd.mul_sel = MUL_SHL;
                state_next  = S_SS3;
            end
            S_SS3:
            begin
                cmd.acc_op  = ACC_SUB;
                cmd.acc_sh  = SH_32;
                cmd.mul_sel = MUL_SHH;
                state_next  = S_SS4;
            end
            S_SS4:
            begin
                cmd.acc_op = ACC_SUB;
                cmd.acc_sh = SH_64;
                state_next = S_DROOT_INIT;
            end
            S_DROOT_INIT:
            begin
                cmd.sq_load = SQ_DEV;
                state_next  = S_DROOT;
            end
            S_DROOT:
            begin
                cmd.sq_step = 1'b1;
                if (status.iter_last)
                begin
                    state_next = S_DIV_INIT;
                end
            end
            S_DIV_INIT:
            begin
                cmd.div_load = 1'b1;
                state_next   = S_DIV;
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (status.iter_last)
                begin
                    state_next = S_THR;
                end
            end
            S_THR:
            begin
                cmd.thr_cap = 1'b1;
                state_next  = S_OUT;
            end
            S_OUT:
            begin
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

FILE: hdl/pdat_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pdat_dp
// Datapath: configuration registers, 32x32 multiplier with wide accumulator,
// bit-serial square root and divider, running statistics and result register.
// ----------------------------------------------------------------------------
module pdat_dp
#(
    parameter int COUNT_WIDTH = pdat_pkg::COUNT_WIDTH_DEF,
    parameter int FRAC_BITS   = pdat_pkg::FRAC_BITS_DEF
)
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [pdat_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [pdat_pkg::CFG_W-1:0]           cfg_data,
    input  logic signed [pdat_pkg::ROT_W-1:0]    rot_diag_0,
    input  logic signed [pdat_pkg::ROT_W-1:0]    rot_diag_1,
    input  logic signed [pdat_pkg::ROT_W-1:0]    rot_diag_2,
    input  logic signed [pdat_pkg::TRANS_W-1:0]  trans_x,
    input  logic signed [pdat_pkg::TRANS_W-1:0]  trans_y,
    input  logic signed [pdat_pkg::TRANS_W-1:0]  trans_z,
    input  pdat_pkg::pdat_cmd_t                  cmd,
    output pdat_pkg::pdat_status_t               status,
    input  logic                                 out_ready,
    output logic                                 out_valid,
    output logic [pdat_pkg::DISP_W-1:0]          displacement,
    output logic                                 accepted,
    output logic [pdat_pkg::DISP_W-1:0]          threshold,
    output logic                                 saturated
);
    import pdat_pkg::*;

    localparam int U_W        = ROT_FRAC + 3;
    localparam int ROOT_W     = FRAC_BITS + 2;
    localparam int ROT_OUT_W  = CFG_W + 2;
    localparam int ROOT_SHIFT = 2 * FRAC_BITS - ROT_FRAC;
    localparam int IT_W       = $clog2(ITER);
    localparam logic [DISP_W-1:0] THR_RST = DISP_W'(64'd2 << FRAC_BITS);
    localparam logic signed [19:0] U_BIAS = 20'sd3 <<< ROT_FRAC;
    localparam logic signed [19:0] U_MAX  = 20'sd4 <<< ROT_FRAC;

    logic [CFG_W-1:0]        max_range_reg;
    logic [CFG_W-1:0]        min_dev_reg;
    logic [U_W-1:0]          u_reg;
    logic [TRANS_W-1:0]      mx_reg;
    logic [TRANS_W-1:0]      my_reg;
    logic [TRANS_W-1:0]      mz_reg;
    logic [63:0]             prod_reg;
    logic [ACC_W-1:0]        acc_reg;
    logic [RAD_W-1:0]        rad_reg;
    logic [ROOT_RES_W+1:0]   rem_reg;
    logic [ROOT_RES_W-1:0]   res_reg;
    logic [IT_W-1:0]         it_cnt_reg;
    logic [63:0]             dq_reg;
    logic [COUNT_WIDTH:0]    dr_reg;
    logic [ROT_OUT_W-1:0]    rot_reg;
    logic [DISP_W-1:0]       disp_reg;
    logic [COUNT_WIDTH-1:0]  count_reg;
    logic [63:0]             sum_reg;
    logic [63:0]             sqsum_reg;
    logic [DISP_W-1:0]       thr_reg;
    logic                    take_reg;
    logic                    rej_reg;
    logic                    out_valid_reg;
    logic [DISP_W-1:0]       out_disp_reg;
    logic                    out_acc_reg;
    logic [DISP_W-1:0]       out_thr_reg;
    logic                    out_sat_reg;

    logic signed [19:0]      trace;
    logic signed [19:0]      u_raw;
    logic [U_W-1:0]          u_next;
    logic [31:0]             mul_a;
    logic [31:0]             mul_b;
    logic [63:0]             prod_next;
    logic [ACC_W-1:0]        addend;
    logic [ACC_W-1:0]        acc_next;
    logic [ROOT_RES_W+1:0]   rem_sh;
    logic [ROOT_RES_W+1:0]   trial;
    logic                    sq_ge;
    logic [COUNT_WIDTH:0]    dr_sh;
    logic [COUNT_WIDTH:0]    divisor;
    logic                    div_ge;
    logic [33:0]             disp_sum;
    logic [64:0]             sq_new;
    logic                    signif;
    logic                    full;
    logic                    take;
    logic [DISP_W-1:0]       thr_sat;

    // fold trace into u = clamp(3 - trace, 0, 4) in Q3.14
    assign trace = 20'(rot_diag_0) + 20'(rot_diag_1) + 20'(rot_diag_2);
    assign u_raw = U_BIAS - trace;

    always_comb
    begin
        if (u_raw < 0)
        begin
            u_next = '0;
        end
        else if (u_raw > U_MAX)
        begin
            u_next = U_W'(U_MAX);
        end
        else
        begin
            u_next = U_W'(u_raw);
        end
    end

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (cmd.mul_sel)
            MUL_ROT:
            begin
                mul_a = 32'(max_range_reg);
                mul_b = 32'(res_reg[ROOT_W-1:0]);
            end
            MUL_TX:
            begin
                mul_a = mx_reg;
                mul_b = mx_reg;
            end
            MUL_TY:
            begin
                mul_a = my_reg;
                mul_b = my_reg;
            end
            MUL_TZ:
            begin
                mul_a = mz_reg;
                mul_b = mz_reg;
            end
            MUL_DISP:
            begin
                mul_a = disp_reg;
                mul_b = disp_reg;
            end
            MUL_NSQ_LO:
            begin
                mul_a = 32'(count_reg);
                mul_b = sqsum_reg[31:0];
            end
            MUL_NSQ_HI:
            begin
                mul_a = 32'(count_reg);
                mul_b = sqsum_reg[63:32];
            end
            MUL_SLL:
            begin
                mul_a = sum_reg[31:0];
                mul_b = sum_reg[31:0];
            end
            MUL_SLH:
            begin
                mul_a = sum_reg[31:0];
                mul_b = sum_reg[63:32];
            end
            MUL_SHL:
            begin
                mul_a = sum_reg[63:32];
                mul_b = sum_reg[31:0];
            end
            MUL_SHH:
            begin
                mul_a = sum_reg[63:32];
                mul_b = sum_reg[63:32];
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod_next = 64'(mul_a) * 64'(mul_b);

    always_comb
    begin
        case (cmd.acc_sh)
            SH_32:   addend = ACC_W'(prod_reg) << 32;
            SH_64:   addend = ACC_W'(prod_reg) << 64;
            default: addend = ACC_W'(prod_reg);
        endcase
    end

    always_comb
    begin
        case (cmd.acc_op)
            ACC_LOAD: acc_next = addend;
            ACC_ADD:  acc_next = acc_reg + addend;
            ACC_SUB:  acc_next = acc_reg - addend;
            default:  acc_next = acc_reg;
        endcase
    end

    // one root bit per step
    assign rem_sh = {rem_reg[ROOT_RES_W-1:0], rad_reg[RAD_W-1 -: 2]};
    assign trial  = {res_reg, 2'b01};
    assign sq_ge  = (rem_sh >= trial);

    // one quotient bit per step
    assign divisor = {1'b0, count_reg};
    assign dr_sh   = {dr_reg[COUNT_WIDTH-1:0], dq_reg[63]};
    assign div_ge  = (dr_sh >= divisor);

    assign disp_sum = 34'(rot_reg) + 34'(res_reg[32:0]);

    assign sq_new = {1'b0, sqsum_reg} + {1'b0, prod_reg};
    assign signif = (disp_reg > DISP_W'(min_dev_reg));
    assign full   = &count_reg;
    assign take   = signif && !full && !sq_new[64];

    always_comb
    begin
        if (dq_reg[63:32] != '0)
        begin
            thr_sat = '1;
        end
        else
        begin
            thr_sat = dq_reg[31:0];
        end
        if (thr_sat < DISP_W'(min_dev_reg))
        begin
            thr_sat = DISP_W'(min_dev_reg);
        end
    end

    assign status.iter_last = (it_cnt_reg == IT_W'(ITER - 1));
    assign status.take      = take;
    assign status.out_free  = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_range_reg <= MAX_RANGE_RST;
            min_dev_reg   <= MIN_DEV_RST;
            count_reg     <= '0;
            sum_reg       <= '0;
            sqsum_reg     <= '0;
            thr_reg       <= THR_RST;
            out_valid_reg <= 1'b0;
            it_cnt_reg    <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_MAX_RANGE:     max_range_reg <= cfg_data;
                    REG_MIN_DEVIATION: min_dev_reg   <= cfg_data;
                    default:           max_range_reg <= max_range_reg;
                endcase
            end
            if (cmd.stat_upd && take)
            begin
                count_reg <= count_reg + 1'b1;
                sum_reg   <= sum_reg + 64'(disp_reg);
                sqsum_reg <= sq_new[63:0];
            end
            if (cmd.thr_cap)
            begin
                thr_reg <= thr_sat;
            end
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (cmd.sq_load != SQ_NONE || cmd.div_load)
            begin
                it_cnt_reg <= '0;
            end
            else if (cmd.sq_step || cmd.div_step)
            begin
                it_cnt_reg <= it_cnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            u_reg  <= u_next;
            mx_reg <= (trans_x < 0) ? TRANS_W'(-trans_x) : TRANS_W'(trans_x);
            my_reg <= (trans_y < 0) ? TRANS_W'(-trans_y) : TRANS_W'(trans_y);
            mz_reg <= (trans_z < 0) ? TRANS_W'(-trans_z) : TRANS_W'(trans_z);
        end
        prod_reg <= prod_next;
        acc_reg  <= acc_next;

        case (cmd.sq_load)
            SQ_ROOT:
            begin
                rad_reg <= RAD_W'(u_reg) << ROOT_SHIFT;
                rem_reg <= '0;
                res_reg <= '0;
            end
            SQ_TRANS:
            begin
                rad_reg <= acc_reg[RAD_W-1:0];
                rem_reg <= '0;
                res_reg <= '0;
            end
            SQ_DEV:
            begin
                if (acc_reg[ACC_W-1])
                begin
                    rad_reg <= '0;
                end
                else
                begin
                    rad_reg <= (acc_reg[RAD_W-1:0] << 3) + acc_reg[RAD_W-1:0];
                end
                rem_reg <= '0;
                res_reg <= '0;
            end
            default:
            begin
                if (cmd.sq_step)
                begin
                    rad_reg <= rad_reg << 2;
                    rem_reg <= sq_ge ? (rem_sh - trial) : rem_sh;
                    res_reg <= {res_reg[ROOT_RES_W-2:0], sq_ge};
                end
            end
        endcase

        if (cmd.div_load)
        begin
            dq_reg <= res_reg;
            dr_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            dq_reg <= {dq_reg[62:0], div_ge};
            dr_reg <= div_ge ? (dr_sh - divisor) : dr_sh;
        end

        if (cmd.rot_cap)
        begin
            rot_reg <= prod_reg[FRAC_BITS +: ROT_OUT_W];
        end
        if (cmd.disp_cap)
        begin
            disp_reg <= (disp_sum[33:32] != 2'b00) ? '1 : disp_sum[31:0];
        end
        if (cmd.stat_upd)
        begin
            take_reg <= take;
            rej_reg  <= signif && !take;
        end
        if (cmd.out_load)
        begin
            out_disp_reg <= disp_reg;
            out_acc_reg  <= take_reg;
            out_thr_reg  <= thr_reg;
            out_sat_reg  <= rej_reg || full;
        end
    end

    assign out_valid    = out_valid_reg;
    assign displacement = out_disp_reg;
    assign accepted     = out_acc_reg;
    assign threshold    = out_thr_reg;
    assign saturated    = out_sat_reg;

endmodule

FILE: hdl/pose_deviation_adaptive_threshold.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pose_deviation_adaptive_threshold
// Each word runs the 64-step square root twice, or three times followed by
// the 64-step divider when a sample is added. One word at a time; the next
// is accepted on return to idle, after the result register has been loaded,
// which waits until the output is free.
// Reset clears the statistics, sets the threshold to 2.0 and the registers to
// their defaults; no clearing pass.
// ----------------------------------------------------------------------------
module pose_deviation_adaptive_threshold
#(
    parameter int COUNT_WIDTH = pdat_pkg::COUNT_WIDTH_DEF,
    parameter int FRAC_BITS   = pdat_pkg::FRAC_BITS_DEF
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [pdat_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [pdat_pkg::CFG_W-1:0]     cfg_data,
    pdat_pose_if.sink                      pose,
    pdat_result_if.source                  result
);
    import pdat_pkg::*;

    pdat_cmd_t    cmd;
    pdat_status_t status;

    pdat_ctrl u_ctrl
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .pose_valid (pose.valid),
        .pose_ready (pose.ready),
        .status     (status),
        .cmd        (cmd)
    );

    pdat_dp
    #(
        .COUNT_WIDTH (COUNT_WIDTH),
        .FRAC_BITS   (FRAC_BITS)
    )
    u_dp
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .rot_diag_0   (pose.rot_diag_0),
        .rot_diag_1   (pose.rot_diag_1),
        .rot_diag_2   (pose.rot_diag_2),
        .trans_x      (pose.trans_x),
        .trans_y      (pose.trans_y),
        .trans_z      (pose.trans_z),
        .cmd          (cmd),
        .status       (status),
        .out_ready    (result.ready),
        .out_valid    (result.valid),
        .displacement (result.displacement),
        .accepted     (result.accepted),
        .threshold    (result.threshold),
        .saturated    (result.saturated)
    );

endmodule
